// File: hdl/row_softmax_core_defines.svh
// Assertion macros used by the checker file rsm_checker.sv
`ifndef ROW_SOFTMAX_CORE_DEFINES_SVH
`define ROW_SOFTMAX_CORE_DEFINES_SVH
`define RSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/rsm_pkg.sv
package rsm_pkg;
  localparam int unsigned Log2eQ16 = 94548;
  localparam int unsigned SumW = 23;

  typedef struct packed {
    logic signed [15:0] value;
    logic               row_end;
  } rsm_in_t;

  typedef struct packed {
    logic [15:0] prob;
    logic        final_res;
    logic        overflowed;
  } rsm_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // store accepted element, track max
    logic drop;      // mark overflow
    logic clr_sum;   // clear sum before exp pass
    logic rd;        // issue store read at rd_addr
    logic acc;       // add exp of read element to sum
    logic div_start; // start divide of read element
    logic row_done;  // reset row state
  } rsm_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } rsm_sts_t;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_EXP   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_RD    = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } rsm_state_e;

  // 2^-(i/depth) in Q1.16, series evaluation at elaboration
  function automatic logic [16:0] exp2_entry(input int unsigned idx, input int unsigned depth);
    logic [63:0] g, x, s, term;
    g = (64'(idx) << 16) / 64'(depth);
    x = (g * 64'd2977044472) >> 16;
    s = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x) >> 32) / 64'(k);
      if (k % 2 == 1) s = s - term;
      else s = s + term;
    end
    return 17'((s + 64'd32768) >> 16);
  endfunction
endpackage

// File: hdl/rsm_ctrl.sv
module rsm_ctrl
  import rsm_pkg::*;
#(
  parameter int unsigned MaxCols = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_row_end_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       out_last_o,
  output rsm_cmd_t                   cmd_o,
  input  rsm_sts_t                   sts_i,
  output logic [$clog2(MaxCols)-1:0] rd_addr_o
);
  localparam int unsigned CntW = $clog2(MaxCols + 1);
  localparam int unsigned AW = $clog2(MaxCols);

  rsm_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic acc_q;
  logic full, acc_item, last_idx;

  assign full = (cnt_q == CntW'(MaxCols));
  assign in_stall_o = (state_q != ST_LOAD);
  assign acc_item = in_valid_i && (state_q == ST_LOAD);
  assign last_idx = (idx_q + CntW'(1) == cnt_q);
  assign rd_addr_o = idx_q[AW-1:0];
  assign out_valid_o = (state_q == ST_OUT);
  assign out_last_o = last_idx;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    cmd_o = '0;
    cmd_o.acc = acc_q;
    case (state_q)
      ST_LOAD: begin
        if (acc_item) begin
          if (full) cmd_o.drop = 1'b1;
          else begin
            cmd_o.load = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end
          if (in_row_end_i) begin
            state_d = ST_EXP;
            idx_d = '0;
            cmd_o.clr_sum = 1'b1;
          end
        end
      end
      ST_EXP: begin
        cmd_o.rd = 1'b1;
        if (idx_q + CntW'(1) == cnt_q) begin
          state_d = ST_DRAIN;
          idx_d = '0;
        end else idx_d = idx_q + CntW'(1);
      end
      ST_DRAIN: begin
        // exp pipeline: read, exp, add
        if (!acc_q) state_d = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_busy && !sts_i.div_done) cmd_o.div_start = 1'b1;
        if (sts_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (last_idx) begin
            state_d = ST_LOAD;
            cnt_d = '0;
            cmd_o.row_done = 1'b1;
          end else begin
            idx_d = idx_q + CntW'(1);
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  logic acc_p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q <= '0;
      idx_q <= '0;
      acc_p_q <= 1'b0;
      acc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      acc_p_q <= (state_q == ST_EXP);
      acc_q <= acc_p_q;
    end
  end
endmodule

// File: hdl/rsm_dpath.sv
module rsm_dpath
  import rsm_pkg::*;
#(
  parameter int unsigned MaxCols = 64,
  parameter int unsigned ExpTableDepth = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [15:0]         value_i,
  input  rsm_cmd_t                   cmd_i,
  input  logic [$clog2(MaxCols)-1:0] rd_addr_i,
  output rsm_sts_t                   sts_o,
  output logic [15:0]                prob_o,
  output logic                       overflowed_o
);
  localparam int unsigned TW = $clog2(ExpTableDepth);

  logic signed [15:0] mem_q [MaxCols];
  logic signed [15:0] rd_q, max_q;
  logic               drop_q;
  logic [SumW-1:0]    sum_q;
  logic [16:0]        e_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem_q[rd_addr_i] <= value_i;
    if (cmd_i.rd) rd_q <= mem_q[rd_addr_i];
  end

  // address port is shared: the top level drives its fill count on rd_addr during load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 16'sh8000;
      drop_q <= 1'b0;
    end else if (cmd_i.row_done) begin
      max_q <= 16'sh8000;
      drop_q <= 1'b0;
    end else begin
      if (cmd_i.load && value_i > max_q) max_q <= value_i;
      if (cmd_i.drop) drop_q <= 1'b1;
    end
  end
  assign overflowed_o = drop_q;

  // exp: d -> t -> table >> n
  logic [15:0] d;
  logic [33:0] t;
  logic [17:0] nwhole;
  logic [TW-1:0] tidx;
  logic [16:0] entry;
  assign d = 16'(max_q - rd_q);
  assign t = 34'((34'(d) * 34'(Log2eQ16) + 34'd128) >> 8);
  assign nwhole = t[33:16];
  assign tidx = TW'((32'(t[15:0]) * 32'(ExpTableDepth)) >> 16);
  always_comb begin
    entry = '0;
    for (int i = 0; i < ExpTableDepth; i++)
      if (tidx == TW'(i)) entry = exp2_entry(i, ExpTableDepth);
  end
  always_ff @(posedge clk_i) begin
    e_q <= (nwhole >= 18'd17) ? 17'd0 : (entry >> nwhole[4:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sum_q <= '0;
    else if (cmd_i.clr_sum) sum_q <= '0;
    else if (cmd_i.acc) sum_q <= sum_q + SumW'(e_q);
  end

  // restoring divider: (e<<16)/sum, one quotient bit per cycle
  localparam int unsigned QW = 33;
  logic [QW-1:0] num_q, quo_q;
  logic [SumW:0] rem_q, rem_sh;
  logic [5:0] step_q;
  logic busy_q, done_q, start_q;
  assign rem_sh = {rem_q[SumW-1:0], num_q[QW-1]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      start_q <= 1'b0;
      num_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      step_q <= '0;
    end else begin
      start_q <= cmd_i.div_start && !start_q;
      if (done_q) done_q <= 1'b0;
      if (start_q) begin
        busy_q <= 1'b1;
        num_q <= {e_q, 16'd0};
        rem_q <= '0;
        quo_q <= '0;
        step_q <= 6'(QW);
      end else if (busy_q) begin
        num_q <= num_q << 1;
        if (rem_sh >= {1'b0, sum_q}) begin
          rem_q <= rem_sh - {1'b0, sum_q};
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
        step_q <= step_q - 6'd1;
        if (step_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
  assign sts_o.div_busy = busy_q || start_q;
  assign sts_o.div_done = done_q;

  logic [15:0] prob_q;
  always_ff @(posedge clk_i) begin
    if (done_q)
      prob_q <= (sum_q == '0) ? 16'd0 : ((quo_q > QW'(65535)) ? 16'hFFFF : quo_q[15:0]);
  end
  assign prob_o = prob_q;
endmodule

// File: hdl/row_softmax_core.sv
// After the row-end item, a row of N stored elements runs the exp/sum pass, then
// yields its probabilities one at a time, each from a store read, divider start,
// the 33-step restoring divider and handoff.
// Loading takes one item per cycle; the exp/sum pass is one element per cycle.
// Reset (rst_ni low, asynchronous) clears the controller, max, sum and drop flag.
module row_softmax_core
  import rsm_pkg::*;
#(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rsm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rsm_out_t out_data_o
);
  localparam int unsigned AW = $clog2(MAX_COLS);
  rsm_cmd_t cmd;
  rsm_sts_t sts;
  logic [AW-1:0] ctrl_addr, mem_addr;
  logic [AW:0] wr_cnt_q;
  logic last;

  // write address follows the fill count while loading
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wr_cnt_q <= '0;
    else if (cmd.row_done) wr_cnt_q <= '0;
    else if (cmd.load) wr_cnt_q <= wr_cnt_q + (AW+1)'(1);
  end
  assign mem_addr = cmd.load ? wr_cnt_q[AW-1:0] : ctrl_addr;

  rsm_ctrl #(.MaxCols(MAX_COLS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_row_end_i(in_data_i.row_end),
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .out_last_o(last),
    .cmd_o(cmd),
    .sts_i(sts),
    .rd_addr_o(ctrl_addr)
  );

  rsm_dpath #(.MaxCols(MAX_COLS), .ExpTableDepth(EXP_TABLE_DEPTH)) u_dpath (
    .clk_i, .rst_ni,
    .value_i(in_data_i.value),
    .cmd_i(cmd),
    .rd_addr_i(mem_addr),
    .sts_o(sts),
    .prob_o(out_data_o.prob),
    .overflowed_o(out_data_o.overflowed)
  );
  assign out_data_o.final_res = last;
endmodule

// File: hdl/rsm_checker.sv
`include "row_softmax_core_defines.svh"
module rsm_checker
  import rsm_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rsm_out_t out_data_o
);
  `RSM_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_o, in_stall_o)
  `RSM_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `RSM_ASSERT_NEXT(a_last_frees, clk_i, rst_ni, out_valid_o && !out_stall_i && out_data_o.final_res, !in_stall_o)
endmodule

bind row_softmax_core rsm_checker u_rsm_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rsm_pkg::*;

  localparam int unsigned MaxCols = 64;
  localparam int unsigned TableDepth = 256;

  class prob_scoreboard;
    int unsigned row_vals[$];
    int          row_max;
    bit          dropped;
    rsm_out_t    pending[$];
    int unsigned errors;

    function new();
      row_max = -32768;
      dropped = 0;
      errors = 0;
    endfunction

    function automatic int unsigned pow2_frac(int unsigned idx);
      longint unsigned g, x, s, term;
      g = (longint'(idx) << 16) / TableDepth;
      x = (g * 64'd2977044472) >> 16;
      s = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x) >> 32) / k;
        if (k % 2 == 1) s = s - term;
        else s = s + term;
      end
      return int'((s + 64'd32768) >> 16);
    endfunction

    function automatic longint unsigned shifted_exp(longint unsigned d);
      longint unsigned t, n, f, idx;
      t = (d * 94548 + 128) >> 8;
      n = t >> 16;
      f = t & 16'hFFFF;
      idx = (f * TableDepth) >> 16;
      if (n >= 17) return 0;
      return longint'(pow2_frac(int'(idx))) >> n;
    endfunction

    // note one accepted element; on row end, queue the row's probabilities
    function void note_element(rsm_in_t it);
      int x;
      longint unsigned sum, e, p;
      rsm_out_t r;
      x = int'(it.value);
      if (row_vals.size() < MaxCols) begin
        row_vals.push_back(x);
        if (x > row_max) row_max = x;
      end else begin
        dropped = 1;
      end
      if (!it.row_end) return;
      sum = 0;
      foreach (row_vals[i]) sum += shifted_exp(longint'(row_max - int'(row_vals[i])));
      sum &= 23'h7FFFFF;
      foreach (row_vals[i]) begin
        e = shifted_exp(longint'(row_max - int'(row_vals[i])));
        p = 0;
        if (sum != 0) begin
          p = (e << 16) / sum;
          if (p > 65535) p = 65535;
        end
        r.prob = p[15:0];
        r.final_res = (i == row_vals.size() - 1);
        r.overflowed = dropped;
        pending.push_back(r);
      end
      row_vals.delete();
      row_max = -32768;
      dropped = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_prob(rsm_out_t got);
      rsm_out_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected probability %h", got));
        return;
      end
      exp_r = pending.pop_front();
      if (got.prob !== exp_r.prob)
        report($sformatf("prob got %0d want %0d", got.prob, exp_r.prob));
      if (got.final_res !== exp_r.final_res)
        report($sformatf("final_res got %b want %b", got.final_res, exp_r.final_res));
      if (got.overflowed !== exp_r.overflowed)
        report($sformatf("overflowed got %b want %b", got.overflowed, exp_r.overflowed));
    endtask
  endclass

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_stall;
  rsm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 0;
  rsm_out_t out_data;

  prob_scoreboard sb = new();
  bit  sending_done = 0;
  int  stall_mode = 0;

  always #4 clk = ~clk;

  row_softmax_core #(.MAX_COLS(MaxCols), .EXP_TABLE_DEPTH(TableDepth)) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_element(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_prob(out_data);
  end

  // receiver stall pattern: phases of none, light and heavy stalling
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  int burst_left = 0;

  // send one element; hold until accepted, with random gaps between bursts
  task automatic send_elem(logic signed [15:0] v, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_data.value <= v;
    in_data.row_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_val(int unsigned mode, int base);
    case (mode)
      0: return 16'($urandom);
      1: return 16'(base + $urandom_range(0, 1024) - 512);
      default: return 16'(base - $urandom_range(0, 8192));
    endcase
  endfunction

  task automatic send_row(int len, int unsigned mode);
    int base;
    base = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < len; i++)
      send_elem(rand_val(mode, base), i == len - 1);
  endtask

  int sent;
  int len;

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    // single elements at the extremes
    send_elem(16'sh7FFF, 1);
    send_elem(-16'sh8000, 1);
    send_elem(16'sh0000, 1);
    // widest spread, then all equal
    send_elem(-16'sh8000, 0);
    send_elem(16'sh7FFF, 0);
    send_elem(16'sh0100, 1);
    send_elem(16'sh1234, 0);
    send_elem(16'sh1234, 0);
    send_elem(16'sh1234, 1);
    // small differences around the table fraction
    send_elem(16'sh0000, 0);
    send_elem(-16'sh0001, 0);
    send_elem(-16'sh00B1, 0);
    send_elem(-16'sh0C00, 1);
    // overflowed row: full length plus drops, max among the dropped ignored
    for (int i = 0; i < MaxCols + 3; i++)
      send_elem(i >= MaxCols ? 16'sh7FFF : 16'(i * 7), i == MaxCols + 2);
    sent = 0;
    while (sent < 300) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(MaxCols - 2, MaxCols + 4);
        1, 2, 3: len = $urandom_range(1, 3);
        default: len = $urandom_range(2, 16);
      endcase
      send_row(len, $urandom_range(0, 2));
      sent += len;
    end
    in_valid <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

// File: files.f
+incdir+hdl
hdl/rsm_pkg.sv
hdl/rsm_ctrl.sv
hdl/rsm_dpath.sv
hdl/row_softmax_core.sv
hdl/rsm_checker.sv
verif/tb_top.sv
